@@ rtl/ptd_pkg.sv @@
package ptd_pkg;

    localparam int HANDLE_W  = 8;
    localparam int PERIOD_W  = 16;
    localparam int COUNTER_W = 32;
    localparam int TIME_W    = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 3;

    // Operation codes carried on s_tuser
    localparam logic [OP_W-1:0] OP_CREATE   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd2;

    // Result status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_CREATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TICK    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

    typedef enum logic {
        ALU_INC,
        ALU_SUB
    } alu_mode_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]  handle;
        logic [PERIOD_W-1:0]  period;
        logic [COUNTER_W-1:0] counter;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

@@ rtl/ptd_ram.sv @@
module ptd_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/ptd_alu.sv @@
module ptd_alu (
    input  ptd_pkg::alu_mode_t                 mode,
    input  logic [ptd_pkg::COUNTER_W-1:0]      counter,
    input  logic [ptd_pkg::PERIOD_W-1:0]       period,
    output logic [ptd_pkg::COUNTER_W-1:0]      result,
    output logic                               due
);
    import ptd_pkg::*;

    logic [COUNTER_W-1:0] period_ext;
    logic [COUNTER_W-1:0] addend;
    logic                 at_max;

    assign period_ext = {{(COUNTER_W-PERIOD_W){1'b0}}, period};
    assign at_max     = &counter;
    assign due        = counter >= period_ext;

    // One adder serves both the saturating increment and the period subtract
    always_comb begin
        case (mode)
            ALU_INC: addend = at_max ? '0 : COUNTER_W'(1);
            ALU_SUB: addend = ~period_ext + COUNTER_W'(1);
            default: addend = '0;
        endcase
    end

    assign result = counter + addend;

endmodule

@@ rtl/periodic_task_dispatcher_unit.sv @@
// Periodic task dispatcher. Keeps a table of TASK_SLOTS task slots (handle, period in ms,
// elapsed counter) in a slot RAM and walks it one slot per cycle, pausing while a result
// waits on a full output register, through a single add/compare unit. The s_tuser
// operation selects create (0), tick (1) or dispatch (2); code 3 is taken and dropped with
// no result. Create returns the first slot whose handle is zero (status 0) or reports a
// full table (status 1). Tick with a new time bumps every counter up to the first empty
// slot, saturating, and returns status 2. Dispatch returns one status 3 transaction per
// due task, in slot order, then a status 4 marker. The final transaction of each operation
// carries m_tlast. One operation is worked at a time and s_tready is low until its last
// result is loaded into the output register. Each walk first reads slot 0 from the
// registered slot RAM; when the walk runs off the table end, a finish state loads the
// closing result. A tick with an unchanged time skips the walk. Slots not yet written
// read as empty through a per-slot valid bit, so no clearing pass follows reset.
module periodic_task_dispatcher_unit #(
    parameter int TASK_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // task_handle[7:0], period_ms[23:8], time_now[55:24]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot_index[2:0], due_handle[10:3], zero pad[15:11]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);
    import ptd_pkg::*;

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [OP_W-1:0]       op_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [TIME_W-1:0]     last_time_reg;
    logic [TASK_SLOTS-1:0] slot_valid_reg;
    logic                  rd_valid_reg;

    logic                  m_tvalid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic [HANDLE_W-1:0]   m_handle_reg;
    logic                  m_last_reg;

    // Input fields
    logic [HANDLE_W-1:0] in_handle;
    logic [PERIOD_W-1:0] in_period;
    logic [TIME_W-1:0]   in_time;
    assign in_handle = s_tdata[7:0];
    assign in_period = s_tdata[23:8];
    assign in_time   = s_tdata[55:24];

    logic s_accept;
    logic out_free;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Slot RAM
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ENTRY_W-1:0]  rd_data;

    ptd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TASK_SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Current slot as seen by the walk; never-written slots read as empty
    slot_entry_t entry;
    logic        empty;
    logic        last_slot;
    assign entry     = rd_valid_reg ? slot_entry_t'(rd_data) : '0;
    assign empty     = (entry.handle == '0);
    assign last_slot = (idx_reg == LAST_IDX);

    // Shared add/compare unit
    alu_mode_t            alu_mode;
    logic [COUNTER_W-1:0] alu_result;
    logic                 alu_due;
    assign alu_mode = (op_reg == OP_TICK) ? ALU_INC : ALU_SUB;

    ptd_alu u_alu (
        .mode    (alu_mode),
        .counter (entry.counter),
        .period  (entry.period),
        .result  (alu_result),
        .due     (alu_due)
    );

    // Slot index, low bits only
    logic [IDX_W+SLOT_W-1:0] idx_ext;
    assign idx_ext = {{SLOT_W{1'b0}}, idx_reg};

    // Walk step decode
    logic                walk_emit;
    logic                walk_step;
    logic                walk_adv;
    logic                walk_end;
    logic [STATUS_W-1:0] walk_status;
    logic [SLOT_W-1:0]   walk_slot;
    logic [HANDLE_W-1:0] walk_handle;
    logic                walk_write;
    logic [STATUS_W-1:0] fin_status;
    logic                tick_walk;
    logic                out_load;

    always_comb begin
        walk_emit   = 1'b0;
        walk_write  = 1'b0;
        walk_status = ST_DONE;
        walk_slot   = '0;
        walk_handle = '0;
        wr_data     = entry;
        case (op_reg)
            OP_CREATE: begin
                walk_emit   = empty;
                walk_write  = empty;
                walk_status = ST_CREATED;
                walk_slot   = idx_ext[SLOT_W-1:0];
                wr_data     = {handle_reg, period_reg, entry.counter};
            end
            OP_TICK: begin
                walk_emit   = empty;
                walk_write  = !empty;
                walk_status = ST_TICK;
                wr_data     = {entry.handle, entry.period, alu_result};
            end
            OP_DISPATCH: begin
                walk_emit   = empty || alu_due;
                walk_write  = !empty && alu_due;
                walk_status = empty ? ST_DONE : ST_DUE;
                walk_slot   = empty ? '0 : idx_ext[SLOT_W-1:0];
                walk_handle = empty ? '0 : entry.handle;
                wr_data     = {entry.handle, entry.period, alu_result};
            end
            default: begin
                walk_emit = empty;
            end
        endcase
    end

    always_comb begin
        case (op_reg)
            OP_CREATE: fin_status = ST_FULL;
            OP_TICK:   fin_status = ST_TICK;
            default:   fin_status = ST_DONE;
        endcase
    end

    assign walk_step = (state_reg == S_WALK) && (!walk_emit || out_free);
    assign walk_adv  = walk_step && !empty && !last_slot;
    assign walk_end  = walk_step && !empty && last_slot;
    assign wr_en     = walk_step && walk_write;
    assign tick_walk = (in_time != last_time_reg);
    assign out_load  = (walk_step && walk_emit) || ((state_reg == S_FINISH) && out_free);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg + IDX_W'(1);
        if (s_accept) begin
            rd_addr = '0;
            case (s_tuser)
                OP_CREATE:   rd_en = 1'b1;
                OP_TICK:     rd_en = tick_walk;
                OP_DISPATCH: rd_en = 1'b1;
                default:     rd_en = 1'b0;
            endcase
        end else begin
            rd_en = walk_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            last_time_reg  <= '0;
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_valid_reg <= slot_valid_reg[rd_addr];
            end
            if (wr_en) begin
                slot_valid_reg[idx_reg] <= 1'b1;
            end

            // Load a new result, or drain the output register
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        op_reg     <= s_tuser;
                        handle_reg <= in_handle;
                        period_reg <= in_period;
                        idx_reg    <= '0;
                        case (s_tuser)
                            OP_CREATE:   state_reg <= S_WALK;
                            OP_DISPATCH: state_reg <= S_WALK;
                            OP_TICK: begin
                                if (tick_walk) begin
                                    last_time_reg <= in_time;
                                    state_reg     <= S_WALK;
                                end else begin
                                    state_reg <= S_FINISH;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_WALK: begin
                    if (walk_step && walk_emit) begin
                        m_status_reg <= walk_status;
                        m_slot_reg   <= walk_slot;
                        m_handle_reg <= walk_handle;
                        m_last_reg   <= empty;
                    end
                    if (walk_step && empty) begin
                        state_reg <= S_IDLE;
                    end else if (walk_end) begin
                        state_reg <= S_FINISH;
                    end else if (walk_adv) begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_status_reg <= fin_status;
                        m_slot_reg   <= '0;
                        m_handle_reg <= '0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(16-HANDLE_W-SLOT_W){1'b0}}, m_handle_reg, m_slot_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ tb/sv/ptd_tb_pkg.sv @@
`timescale 1ns / 1ps
package ptd_tb_pkg;

    import ptd_pkg::*;

    localparam int TB_SLOTS = 8;

    // Operation code that the unit takes and drops
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } reply_t;

    class task_table_scoreboard;

        logic [HANDLE_W-1:0]  handles  [TB_SLOTS];
        logic [PERIOD_W-1:0]  periods  [TB_SLOTS];
        logic [COUNTER_W-1:0] counters [TB_SLOTS];
        logic [TIME_W-1:0]    last_ms;
        reply_t               pending_replies[$];
        int                   errors;

        function new();
            for (int i = 0; i < TB_SLOTS; i++) begin
                handles[i]  = '0;
                periods[i]  = '0;
                counters[i] = '0;
            end
            last_ms = '0;
            errors  = 0;
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction

        function void push_reply(logic [STATUS_W-1:0] status, int slot,
                                 logic [HANDLE_W-1:0] handle, logic last);
            pending_replies.push_back({status, SLOT_W'(slot), handle, last});
        endfunction

        // Update the task table and queue the replies one request causes.
        function void add_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                                  logic [PERIOD_W-1:0] period, logic [TIME_W-1:0] now);
            int  i;
            bit  placed;
            placed = 1'b0;
            case (op)
                OP_CREATE: begin
                    for (i = 0; i < TB_SLOTS && !placed; i++) begin
                        if (handles[i] == '0) begin
                            handles[i] = handle;
                            periods[i] = period;
                            push_reply(ST_CREATED, i, '0, 1'b1);
                            placed = 1'b1;
                        end
                    end
                    if (!placed) push_reply(ST_FULL, 0, '0, 1'b1);
                end
                OP_TICK: begin
                    if (now != last_ms) begin
                        last_ms = now;
                        for (i = 0; i < TB_SLOTS && handles[i] != '0; i++) begin
                            if (counters[i] != '1) counters[i] = counters[i] + 1'b1;
                        end
                    end
                    push_reply(ST_TICK, 0, '0, 1'b1);
                end
                OP_DISPATCH: begin
                    for (i = 0; i < TB_SLOTS && handles[i] != '0; i++) begin
                        if (counters[i] >= COUNTER_W'(periods[i])) begin
                            counters[i] = counters[i] - COUNTER_W'(periods[i]);
                            push_reply(ST_DUE, i, handles[i], 1'b0);
                        end
                    end
                    push_reply(ST_DONE, 0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: result with none expected, actual status %0d slot %0d handle %0h last %0b",
                         $time, got.status, got.slot, got.handle, got.last);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("slot_index", 8'(want.slot), 8'(got.slot));
            compare_field("due_handle", want.handle, got.handle);
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction

    endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

    import ptd_pkg::*;
    import ptd_tb_pkg::*;

    // Cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    // Settle time after the last expected result, above the longest walk
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // task_handle[7:0], period_ms[23:8], time_now[55:24]
    logic [1:0]  s_tuser;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // slot_index[2:0], due_handle[10:3], zero pad[15:11]
    logic [2:0]  m_tuser;   // status[2:0]
    logic        m_tlast;

    task_table_scoreboard sb;
    bit                   sender_gaps;
    bit                   sink_stalls;
    logic [TIME_W-1:0]    clock_ms;
    int                   quiet_cycles;

    periodic_task_dispatcher_unit #(
        .TASK_SLOTS(TB_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: stall at random on the falling edge, or hold ready high
    // while stalls are switched off.
    always @(negedge aclk) begin
        m_tready <= sink_stalls ? ($urandom_range(99) >= 22) : 1'b1;
    end

    // Sample both channels on the rising edge: feed accepted requests to the
    // predictor, check accepted results, and count idle cycles for the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.add_request(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[55:24]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_reply({m_tuser, m_tdata[2:0], m_tdata[10:3], m_tlast});
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // Drive one request from the falling edge and hold it until the unit
    // takes it; insert random gaps first when gaps are enabled.
    task automatic send_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                                logic [PERIOD_W-1:0] period, logic [TIME_W-1:0] now);
        @(negedge aclk);
        while (sender_gaps && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {now, period, handle};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    initial begin
        int pick;
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        sender_gaps  = 1'b1;
        sink_stalls  = 1'b1;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty table, unchanged time, handle zero, extremes.
        send_request(OP_DISPATCH, 8'h00, 16'h0000, 32'h0000_0000);  // empty table
        send_request(OP_TICK,     8'hFF, 16'hFFFF, 32'h0000_0000);  // same time as reset
        send_request(OP_CREATE,   8'h00, 16'hFFFF, 32'hFFFF_FFFF);  // handle zero stays empty
        send_request(OP_TICK,     8'h00, 16'h0000, 32'hFFFF_FFFF);  // walk stops at slot 0
        send_request(OP_DISPATCH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_CREATE,   8'hFF, 16'h0000, 32'h0000_0000);  // period zero
        send_request(OP_CREATE,   8'h01, 16'h0001, 32'h0000_0000);
        send_request(OP_CREATE,   8'h80, 16'hFFFF, 32'h0000_0000);  // largest period
        send_request(OP_TICK,     8'h00, 16'h0000, 32'hFFFF_FFFF);  // unchanged time
        send_request(OP_TICK,     8'h00, 16'h0000, 32'h0000_0000);
        send_request(OP_TICK,     8'h00, 16'h0000, 32'h0000_0001);
        send_request(OP_DISPATCH, 8'h00, 16'h0000, 32'h0000_0000);
        send_request(OP_UNUSED,   8'hFF, 16'hFFFF, 32'hFFFF_FFFF);  // dropped, no result
        for (int k = 0; k < 5; k++) begin
            send_request(OP_CREATE, 8'(8'h40 + k), 16'(k + 2), 32'h0000_0000);
        end
        send_request(OP_CREATE,   8'h55, 16'h0003, 32'h0000_0000);  // table full
        send_request(OP_CREATE,   8'h00, 16'h0000, 32'h0000_0000);  // full, handle zero
        send_request(OP_TICK,     8'h00, 16'h0000, 32'h0000_0002);
        send_request(OP_TICK,     8'h00, 16'h0000, 32'h0000_0003);
        send_request(OP_DISPATCH, 8'h00, 16'h0000, 32'h0000_0000);

        // Random part: mostly advancing ticks and dispatches with junk in the
        // unused fields, a few creates and dropped codes.
        clock_ms = 32'h0000_0003;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            if (n == 250) begin
                sender_gaps = 1'b1;
                sink_stalls = 1'b1;
            end
            // Drop valid and hold the sender until every pending result has drained.
            if (n == 200) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (sb.outstanding() != 0) @(posedge aclk);
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                case ($urandom_range(19))
                    0:       ;                              // repeat the same time
                    1:       clock_ms = $urandom();        // jump anywhere
                    default: clock_ms = clock_ms + 1'b1;
                endcase
                send_request(OP_TICK, 8'($urandom()), 16'($urandom()), clock_ms);
            end else if (pick < 85) begin
                send_request(OP_DISPATCH, 8'($urandom()), 16'($urandom()), $urandom());
            end else if (pick < 95) begin
                send_request(OP_CREATE, 8'($urandom()), 16'($urandom()), $urandom());
            end else begin
                send_request(OP_UNUSED, 8'($urandom()), 16'($urandom()), $urandom());
            end
        end

        // Drop valid, wait for the last results, then let the unit settle.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
